FILE: design/vn_pkg.sv
`timescale 1ns / 1ps

package vn_pkg;

   // Default component width: signed Q15.16.
   localparam int COMPONENT_WIDTH_DEF = 32;

   // Default number of fraction bits of each unit component: Q1.14.
   localparam int UNIT_FRACTION_BITS_DEF = 14;

   // Width of the minimum-magnitude register.
   localparam int CSR_WIDTH = 32;

   // Reset value of the minimum magnitude: 0.0001 rounded up to Q16.16.
   localparam logic [CSR_WIDTH-1:0] MIN_MAG_RESET = 32'd7;

   // Sideband flags that travel with an item through the divider.
   typedef struct packed {
      logic       too_small;
      logic [2:0] neg;
   } vn_flags_type;

endpackage

FILE: design/vn_sqrt.sv
`timescale 1ns / 1ps

// Pipelined integer square root: one result bit per stage, W stages.
// The root is the floor of the square root of a 2*W bit radicand.
module vn_sqrt #(
   parameter int W      = 32,
   parameter int SIDE_W = 99
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2*W-1:0]    in_rad,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [W-1:0]      out_root,
   output logic [SIDE_W-1:0] out_side
);

   // Per-stage registers; each entry belongs to one fixed stage.
   logic              valid_ff [W];
   logic [W:0]        rem_ff   [W];
   logic [W-1:0]      root_ff  [W];
   logic [2*W-1:0]    rad_ff   [W];
   logic [SIDE_W-1:0] side_ff  [W];

   for (genvar k = 0; k < W; k++) begin : g_step
      logic              cur_valid;
      logic [W:0]        cur_rem;
      logic [W-1:0]      cur_root;
      logic [2*W-1:0]    cur_rad;
      logic [SIDE_W-1:0] cur_side;
      logic [W+1:0]      rem_sh;
      logic [W+1:0]      trial;
      logic              take;
      logic [W+1:0]      rem_diff;

      // Stage input: the module ports for the first stage, else the stage before.
      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_rad   = in_rad;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_rem   = rem_ff[k-1];
         assign cur_root  = root_ff[k-1];
         assign cur_rad   = rad_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      // Bring down the next two radicand bits and try the next root bit.
      assign rem_sh   = {cur_rem[W-1:0], cur_rad[2*W-1 -: 2]};
      assign trial    = {cur_root, 2'b01};
      assign take     = (rem_sh >= trial);
      assign rem_diff = rem_sh - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? rem_diff[W:0] : rem_sh[W:0];
            root_ff[k] <= {cur_root[W-2:0], take};
            rad_ff[k]  <= {cur_rad[2*W-3:0], 2'b00};
            side_ff[k] <= cur_side;
         end
      end
   end

   assign out_valid = valid_ff[W-1];
   assign out_root  = root_ff[W-1];
   assign out_side  = side_ff[W-1];

endmodule

FILE: design/vn_divide.sv
`timescale 1ns / 1ps

// Pipelined restoring divider for three lanes sharing one divisor.
// Each lane gives trunc(a * 2^F / mag) for a <= mag, one quotient bit per stage.
module vn_divide #(
   parameter int W      = 32,
   parameter int F      = 14,
   parameter int SIDE_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [W-1:0]        in_mag,
   input  logic [3*W-1:0]      in_abs,
   input  logic [SIDE_W-1:0]   in_side,
   output logic                out_valid,
   output logic [W-1:0]        out_mag,
   output logic [3*(F+1)-1:0]  out_quo,
   output logic [SIDE_W-1:0]   out_side
);

   localparam int STAGES = F + 1;

   logic              valid_ff [STAGES];
   logic [W-1:0]      mag_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];
   logic [W-1:0]      rem_ff   [STAGES][3];
   logic [F:0]        quo_ff   [STAGES][3];

   for (genvar k = 0; k < STAGES; k++) begin : g_step
      logic              cur_valid;
      logic [W-1:0]      cur_mag;
      logic [SIDE_W-1:0] cur_side;

      if (k == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_mag   = in_mag;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[k-1];
         assign cur_mag   = mag_ff[k-1];
         assign cur_side  = side_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[k]  <= cur_mag;
            side_ff[k] <= cur_side;
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [W:0] rem_sh;
         logic       take;
         logic [W:0] rem_diff;

         // The first stage yields the integer bit; later stages shift in one bit.
         if (k == 0) begin : g_int
            assign rem_sh = {1'b0, in_abs[l*W +: W]};
         end else begin : g_frac
            assign rem_sh = {rem_ff[k-1][l], 1'b0};
         end
         assign take     = (rem_sh >= {1'b0, cur_mag});
         assign rem_diff = rem_sh - {1'b0, cur_mag};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l] <= take ? rem_diff[W-1:0] : rem_sh[W-1:0];
            end
         end

         // Quotient bits collect from the integer bit down.
         if (k == 0) begin : g_quo_first
            always_ff @(posedge clock) begin
               if (en) begin
                  quo_ff[k][l] <= (F+1)'(take);
               end
            end
         end else begin : g_quo_next
            always_ff @(posedge clock) begin
               if (en) begin
                  quo_ff[k][l] <= {quo_ff[k-1][l][F-1:0], take};
               end
            end
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_out
      assign out_quo[l*(F+1) +: F+1] = quo_ff[STAGES-1][l];
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_mag   = mag_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

FILE: design/vector3_normalize.sv
`timescale 1ns / 1ps

// Three-component vector normalizer, fully pipelined.
// req_tdata carries x, y and z as signed fixed point (Q15.16 by default).
// rsp_tdata returns the magnitude (floor of the Euclidean length, same scale)
// and the three unit components in signed Q1.14, truncated toward zero;
// rsp_tuser is set when the magnitude is zero or below the minimum held in the
// csr register, and the unit components are then zero.
// The csr channel is always ready; write it only while no transaction is in flight.
// The stages in order are absolute value, squaring, summing, the square root
// stages, the minimum compare, the divider stages and the output register.
// Throughput is one transaction per cycle unless stalled; all stages move together.
// When rsp_tready is low with a result waiting, every stage holds and req_tready
// drops; bubbles in the pipeline do not fill while stalled.
// Reset clears all valid bits and sets the minimum magnitude to 7 (0.0001).
module vector3_normalize #(
   parameter int COMPONENT_WIDTH    = vn_pkg::COMPONENT_WIDTH_DEF,
   parameter int UNIT_FRACTION_BITS = vn_pkg::UNIT_FRACTION_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // Fields from bit 0: x_in, y_in, z_in, zero padding.
   input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // Fields from bit 0: magnitude, unit_x, unit_y, unit_z, zero padding.
   output logic [((COMPONENT_WIDTH+3*(UNIT_FRACTION_BITS+2)+7)/8)*8-1:0] rsp_tdata,
   // Fields from bit 0: too_small.
   output logic [0:0] rsp_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [vn_pkg::CSR_WIDTH-1:0] csr_data,
   input  logic csr_valid,
   output logic csr_ready
);

   import vn_pkg::*;

   localparam int W      = COMPONENT_WIDTH;
   localparam int F      = UNIT_FRACTION_BITS;
   localparam int U      = F + 2;
   localparam int OUT_W  = ((W+3*U+7)/8)*8;
   localparam int SIDE_W = 3*W + 3;
   localparam int CMP_W  = (W > CSR_WIDTH) ? W : CSR_WIDTH;

   logic                 en;
   logic [CSR_WIDTH-1:0] min_mag_ff;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic [W-1:0]         abs1_ff [3];
   logic [2:0]           neg1_ff;
   logic [2*W-1:0]       sq2_ff [3];
   logic [SIDE_W-1:0]    side2_ff, side3_ff;
   logic [2*W-1:0]       sum3_ff;

   logic                 sq_valid;
   logic [W-1:0]         sq_root;
   logic [SIDE_W-1:0]    sq_side;
   logic [CMP_W-1:0]     root_ext, min_ext;

   logic [W-1:0]         mag4_ff;
   logic [3*W-1:0]       abs4_ff;
   vn_flags_type         flags4_ff;

   logic                 dv_valid;
   logic [W-1:0]         dv_mag;
   logic [3*(F+1)-1:0]   dv_quo;
   vn_flags_type         dv_flags;

   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff;
   logic                 rsp_small_ff;
   logic [OUT_W-1:0]     rsp_data_in;

   // The pipeline moves when the output register is free or being emptied.
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // Minimum magnitude register.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_mag_ff <= MIN_MAG_RESET;
      end else if (csr_valid) begin
         min_mag_ff <= csr_data;
      end
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= sq_valid;
      end
   end

   // Stage 1: absolute value and sign; the most negative value stays exact.
   for (genvar i = 0; i < 3; i++) begin : g_abs
      logic [W-1:0] raw;
      assign raw = req_tdata[i*W +: W];
      always_ff @(posedge clock) begin
         if (en) begin
            neg1_ff[i] <= raw[W-1];
            abs1_ff[i] <= raw[W-1] ? (~raw + 1'b1) : raw;
         end
      end
   end

   // Stages 2 and 3: squares, then their sum, which always fits 2*W bits.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= (2*W)'(abs1_ff[i]) * (2*W)'(abs1_ff[i]);
         end
         side2_ff <= {neg1_ff, abs1_ff[2], abs1_ff[1], abs1_ff[0]};
         sum3_ff  <= sq2_ff[0] + sq2_ff[1] + sq2_ff[2];
         side3_ff <= side2_ff;
      end
   end

   vn_sqrt #(
      .W      (W),
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .in_rad    (sum3_ff),
      .in_side   (side3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Stage after the root: a zero or sub-minimum magnitude forces a zero vector.
   assign root_ext = CMP_W'(sq_root);
   assign min_ext  = CMP_W'(min_mag_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         mag4_ff             <= sq_root;
         abs4_ff             <= sq_side[3*W-1:0];
         flags4_ff.neg       <= sq_side[3*W +: 3];
         flags4_ff.too_small <= (sq_root == '0) || (root_ext < min_ext);
      end
   end

   vn_divide #(
      .W      (W),
      .F      (F),
      .SIDE_W ($bits(vn_flags_type))
   ) u_divide (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_mag    (mag4_ff),
      .in_abs    (abs4_ff),
      .in_side   (flags4_ff),
      .out_valid (dv_valid),
      .out_mag   (dv_mag),
      .out_quo   (dv_quo),
      .out_side  (dv_flags)
   );

   // Output formatting: apply sign, or zero when too small.
   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[W-1:0] = dv_mag;
      for (int i = 0; i < 3; i++) begin
         if (dv_flags.too_small) begin
            rsp_data_in[W + i*U +: U] = '0;
         end else if (dv_flags.neg[i]) begin
            rsp_data_in[W + i*U +: U] = ~U'(dv_quo[i*(F+1) +: F+1]) + 1'b1;
         end else begin
            rsp_data_in[W + i*U +: U] = U'(dv_quo[i*(F+1) +: F+1]);
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_small_ff <= dv_flags.too_small;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_small_ff;

   // A forced result carries zero unit components.
   a_small_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[W +: 3*U] == '0)
      else $error("too_small result with nonzero unit components");

   // A normal result never has a zero magnitude.
   a_mag_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[W-1:0] != '0)
      else $error("unit result produced for zero magnitude");

   // Unit components stay at or below plus one.
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[W +: U]) <= $signed(U'(1) << F))
         && ($signed(rsp_tdata[W + U +: U]) <= $signed(U'(1) << F))
         && ($signed(rsp_tdata[W + 2*U +: U]) <= $signed(U'(1) << F)))
      else $error("unit component above one");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

FILE: dv/tb_vector3_normalize.sv
`timescale 1ns / 1ps

module tb_vector3_normalize;
   import vn_pkg::*;

   localparam int CW = 32;
   localparam int UF = 14;
   localparam int UW = UF + 2;
   localparam int REQ_W = ((3*CW+7)/8)*8;
   localparam int RSP_W = ((CW+3*UW+7)/8)*8;
   localparam int LATENCY = CW + UF + 6;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
   } vec_type;

   typedef struct packed {
      logic [CW-1:0] mag;
      logic [UW-1:0] ux;
      logic [UW-1:0] uy;
      logic [UW-1:0] uz;
      logic          forced;
   } norm_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [CSR_WIDTH-1:0] csr_data = '0;
   logic csr_valid = 1'b0;
   logic csr_ready;

   vec_type  vec_queue[$];
   norm_type norm_queue[$];
   logic [CSR_WIDTH-1:0] min_mag = MIN_MAG_RESET;
   int mismatches = 0;
   int send_gap = 0;
   int recv_gap = 0;
   bit stall_free = 0;

   vector3_normalize DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_data(csr_data), .csr_valid(csr_valid), .csr_ready(csr_ready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected normalization of one vector under the current minimum.
   function automatic norm_type normalize(vec_type v);
      norm_type r;
      logic [CW-1:0] a[3];
      logic neg[3];
      logic [CW-1:0] comp[3];
      logic [127:0] sum;
      logic [127:0] cand;
      logic [63:0] root;
      logic [63:0] q;
      logic [63:0] rem;
      logic [UW-1:0] u[3];
      comp[0] = v.x; comp[1] = v.y; comp[2] = v.z;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = comp[i][CW-1];
         a[i] = neg[i] ? -comp[i] : comp[i];
         sum += 128'(a[i]) * 128'(a[i]);
      end
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = 128'(root | (64'd1 << b));
         if (cand * cand <= sum) root = root | (64'd1 << b);
      end
      r.mag = root[CW-1:0];
      if (r.mag == 0 || r.mag < min_mag) begin
         r.ux = '0; r.uy = '0; r.uz = '0; r.forced = 1'b1;
      end else begin
         for (int i = 0; i < 3; i++) begin
            q = (64'(a[i]) << UF) / 64'(r.mag);
            u[i] = neg[i] ? -q[UW-1:0] : q[UW-1:0];
         end
         r.ux = u[0]; r.uy = u[1]; r.uz = u[2]; r.forced = 1'b0;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      if (stall_free) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic logic [CW-1:0] rand_comp();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return CW'($signed($urandom_range(0, 40)) - 20);
         3: return CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom();
      endcase
   endfunction

   // Driver: presents queued vectors with random gaps, x in the lowest bits.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            norm_queue.push_back(normalize(vec_queue.pop_front()));
            send_gap = pick_gap();
         end
         if (send_gap > 0 && !(req_tvalid && !req_tready)) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (vec_queue.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_W'({vec_queue[0].z, vec_queue[0].y, vec_queue[0].x});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: checks each result transaction against the oldest expectation and drives rsp_tready with random gaps.
   always @(posedge clock) begin
      norm_type got;
      norm_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.mag = rsp_tdata[CW-1:0];
            got.ux = rsp_tdata[CW +: UW];
            got.uy = rsp_tdata[CW+UW +: UW];
            got.uz = rsp_tdata[CW+2*UW +: UW];
            got.forced = rsp_tuser[0];
            if (norm_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected result %h", got);
            end else begin
               want = norm_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"Mismatch: expected mag %h u %h %h %h s %b, ",
                               "got mag %h u %h %h %h s %b"},
                              want.mag, want.ux, want.uy, want.uz, want.forced,
                              got.mag, got.ux, got.uy, got.uz, got.forced);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_gap = pick_gap();
         end
      end
   end

   task automatic write_min(logic [CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      min_mag = value;
   endtask

   task automatic drain();
      while (vec_queue.size() > 0 || norm_queue.size() > 0 || req_tvalid) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic push_vec(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
      vec_type v;
      v.x = x; v.y = y; v.z = z;
      vec_queue.push_back(v);
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] settings[5];
      settings = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd7, 32'h0000_0100};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // Directed vectors at reset minimum.
      push_vec(0, 0, 0);
      push_vec(32'h8000_0000, 0, 0);
      push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_vec(32'h7FFF_FFFF, 32'h8000_0000, 0);
      push_vec(6, 0, 0);
      push_vec(7, 0, 0);
      push_vec(0, 32'hFFFF_FFF9, 0);
      push_vec(32'h0001_0000, 32'h0001_0000, 0);
      push_vec(3, 4, 0);
      push_vec(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      push_vec(32'hFFFF_0000, 32'h0002_0000, 32'hFFFE_0000);
      drain();
      // Zero minimum: zero vector still flagged, tiny vectors divided.
      write_min(0);
      push_vec(0, 0, 0);
      push_vec(1, 0, 0);
      push_vec(0, 0, 32'hFFFF_FFFF);
      push_vec(32'h8000_0000, 32'h7FFF_FFFF, 1);
      drain();
      write_min(32'hFFFF_FFFF);
      push_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_vec(32'h7FFF_FFFF, 0, 0);
      drain();
      // Random phases across several minimum settings.
      for (int p = 0; p < 9; p++) begin
         write_min(p < 5 ? settings[p] : $urandom());
         stall_free = (p == 3);
         for (int n = 0; n < 150; n++) push_vec(rand_comp(), rand_comp(), rand_comp());
         drain();
      end
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
